[sv/ordered_completion_ring_core_defines.svh]
`ifndef ORDERED_COMPLETION_RING_CORE_DEFINES_SVH
`define ORDERED_COMPLETION_RING_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define OCR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ordered completion ring: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define OCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ordered completion ring: next-cycle check failed");

`endif

[sv/ocr_pkg.sv]
`timescale 1ns / 1ps

package ocr_pkg;

   localparam int RING_DEPTH_DEF   = 1024;
   localparam int MAX_BATCH_DEF    = 16;
   localparam int PAYLOAD_BITS_DEF = 64;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_RING_LENGTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BATCH_BUDGET = 4'd1;

   localparam logic [10:0] RING_LENGTH_RESET = 11'd1024;

   localparam logic [2:0] MODE_ENQ   = 3'd0;
   localparam logic [2:0] MODE_FIN   = 3'd1;
   localparam logic [2:0] MODE_CLAIM = 3'd2;
   localparam logic [2:0] MODE_CMP   = 3'd3;
   localparam logic [2:0] MODE_DEQ   = 3'd4;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_FULL   = 3'd1;
   localparam logic [2:0] ST_NONE   = 3'd2;
   localparam logic [2:0] ST_CLOSED = 3'd3;
   localparam logic [2:0] ST_BAD    = 3'd4;

   localparam logic [1:0] RD_CLAIM = 2'd0;
   localparam logic [1:0] RD_CMP   = 2'd1;
   localparam logic [1:0] RD_DEQ   = 2'd2;
   localparam logic [1:0] RD_SLOT  = 2'd3;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] item_cost;
      logic [63:0] payload;
      logic [9:0]  slot_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [9:0]  claimed_slot;
      logic        item_valid;
      logic [63:0] data_out;
      logic        end_of_stream;
      logic        last_of_run;
      logic [10:0] unclaimed_count;
      logic [10:0] ready_count;
   } rsp_type;

   typedef struct packed {
      logic       take_req;
      logic       do_store;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       claim_adv;
      logic       sw1_step;
      logic       sw2_step;
      logic       do_cmp;
      logic       deq_pop;
      logic       do_clear;
      logic       push_err;
      logic [2:0] err_code;
      logic       emit_load;
   } cmd_type;

   typedef struct packed {
      logic [2:0] req_mode;
      logic       closed;
      logic       full;
      logic       pend_zero;
      logic       infl_zero;
      logic       rdy_zero;
      logic       rd_done;
      logic       rd_end;
      logic       range_bad;
      logic       claim_stop;
      logic       buf_empty;
      logic       emit_last;
      logic       rsp_free;
   } stat_type;

endpackage

[sv/ordered_completion_ring_core.sv]
`timescale 1ns / 1ps
// Ordered completion ring: a reorder buffer held in one ring of slots.
// Requests enter on req_valid/req_stall with a req_data struct (mode, cost,
// payload, slot index); results leave on rsp_valid/rsp_stall as rsp_data.
// Enqueue, finish, complete and dequeue give one result each; a claim gives
// one result per slot handed out, up to MAX_BATCH, with last_of_run set on
// the final one. Unused modes give no result.
// One request is worked on at a time. Each visit to a ring slot is a read
// state and a check state, as the slot memory has one port with a registered
// read. After acceptance a store writes its slot, a complete or a dequeue
// visits at most one slot, and a claim checks its stop condition before each
// slot it visits. The two sweeps, skipped by errors and dequeues, then visit
// slots up to the one where each stops, or move on with nothing to pass.
// Results are collected in a small buffer and issued through an output
// register at one per cycle while rsp_stall is low, once the request has
// finished, so the counts are final; an empty claim first buffers a status
// result. A stalled receiver holds the result and holds the block in that
// phase. Registers are written on csr_valid/csr_ready (always high); the
// user must do so only while the block is idle, which it does not enforce.
// Synchronous reset empties the ring, opens the queue, sets ring_length to
// 1024 and batch_budget to 0. No clearing pass is needed.

`include "ordered_completion_ring_core_defines.svh"

module ordered_completion_ring_core #(
   parameter int RING_DEPTH   = ocr_pkg::RING_DEPTH_DEF,
   parameter int MAX_BATCH    = ocr_pkg::MAX_BATCH_DEF,
   parameter int PAYLOAD_BITS = ocr_pkg::PAYLOAD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  ocr_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ocr_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ocr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ocr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   ocr_pkg::cmd_type  cmd;
   ocr_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   ocr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   ocr_dpath #(
      .RING_DEPTH   (RING_DEPTH),
      .MAX_BATCH    (MAX_BATCH),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   `OCR_ASSERT_NOW(a_emit_when_free, clock, reset, cmd.emit_load, stat.rsp_free)
   `OCR_ASSERT_NEXT(a_read_then_check, clock, reset, cmd.rd_en, !cmd.rd_en)
   `OCR_ASSERT_NEXT(a_busy_after_accept, clock, reset,
      req_valid && !req_stall && (req_data.mode <= ocr_pkg::MODE_DEQ), req_stall)

endmodule

[sv/ocr_ctrl.sv]
`timescale 1ns / 1ps

module ocr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  ocr_pkg::stat_type  stat,
   output ocr_pkg::cmd_type   cmd,
   output logic               req_stall
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_STORE     = 4'd1;
   localparam logic [3:0] S_CLAIM_RD  = 4'd2;
   localparam logic [3:0] S_CLAIM_CHK = 4'd3;
   localparam logic [3:0] S_CMP_RD    = 4'd4;
   localparam logic [3:0] S_CMP_CHK   = 4'd5;
   localparam logic [3:0] S_DEQ_RD    = 4'd6;
   localparam logic [3:0] S_DEQ_CHK   = 4'd7;
   localparam logic [3:0] S_SW1_RD    = 4'd8;
   localparam logic [3:0] S_SW1_CHK   = 4'd9;
   localparam logic [3:0] S_SW2_RD    = 4'd10;
   localparam logic [3:0] S_SW2_CHK   = 4'd11;
   localparam logic [3:0] S_EMIT      = 4'd12;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take_req = 1'b1;
               unique case (stat.req_mode) inside
                  ocr_pkg::MODE_ENQ, ocr_pkg::MODE_FIN: state_in = S_STORE;
                  ocr_pkg::MODE_CLAIM: state_in = S_CLAIM_RD;
                  ocr_pkg::MODE_CMP:   state_in = S_CMP_RD;
                  ocr_pkg::MODE_DEQ:   state_in = S_DEQ_RD;
                  default:             state_in = S_IDLE;
               endcase
            end
         end
         S_STORE: begin
            if (stat.closed) begin
               cmd.push_err = 1'b1;
               cmd.err_code = ocr_pkg::ST_CLOSED;
               state_in     = S_EMIT;
            end else if (stat.full) begin
               cmd.push_err = 1'b1;
               cmd.err_code = ocr_pkg::ST_FULL;
               state_in     = S_EMIT;
            end else begin
               cmd.do_store = 1'b1;
               state_in     = S_SW1_RD;
            end
         end
         S_CLAIM_RD: begin
            if (stat.claim_stop) begin
               state_in = S_SW1_RD;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ocr_pkg::RD_CLAIM;
               state_in   = S_CLAIM_CHK;
            end
         end
         S_CLAIM_CHK: begin
            cmd.claim_adv = 1'b1;
            state_in      = S_CLAIM_RD;
         end
         S_CMP_RD: begin
            if (stat.range_bad) begin
               cmd.push_err = 1'b1;
               cmd.err_code = ocr_pkg::ST_BAD;
               state_in     = S_EMIT;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ocr_pkg::RD_SLOT;
               state_in   = S_CMP_CHK;
            end
         end
         S_CMP_CHK: begin
            if (stat.rd_done) begin
               cmd.push_err = 1'b1;
               cmd.err_code = ocr_pkg::ST_BAD;
               state_in     = S_EMIT;
            end else begin
               cmd.do_cmp = 1'b1;
               state_in   = S_SW1_RD;
            end
         end
         S_DEQ_RD: begin
            if (stat.rdy_zero) begin
               cmd.push_err = 1'b1;
               cmd.err_code = ocr_pkg::ST_NONE;
               state_in     = S_EMIT;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ocr_pkg::RD_DEQ;
               state_in   = S_DEQ_CHK;
            end
         end
         S_DEQ_CHK: begin
            if (stat.rd_end) begin
               cmd.do_clear = 1'b1;
            end else begin
               cmd.deq_pop = 1'b1;
            end
            state_in = S_EMIT;
         end
         S_SW1_RD: begin
            if (stat.pend_zero) begin
               state_in = S_SW2_RD;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ocr_pkg::RD_CLAIM;
               state_in   = S_SW1_CHK;
            end
         end
         S_SW1_CHK: begin
            if (stat.rd_done) begin
               cmd.sw1_step = 1'b1;
               state_in     = S_SW1_RD;
            end else begin
               state_in = S_SW2_RD;
            end
         end
         S_SW2_RD: begin
            if (stat.infl_zero) begin
               state_in = S_EMIT;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ocr_pkg::RD_CMP;
               state_in   = S_SW2_CHK;
            end
         end
         S_SW2_CHK: begin
            if (stat.rd_done) begin
               cmd.sw2_step = 1'b1;
               state_in     = S_SW2_RD;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (stat.buf_empty) begin
               cmd.push_err = 1'b1;
               cmd.err_code = ocr_pkg::ST_NONE;
            end else if (stat.rsp_free) begin
               cmd.emit_load = 1'b1;
               if (stat.emit_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/ocr_dpath.sv]
`timescale 1ns / 1ps

module ocr_dpath #(
   parameter int RING_DEPTH   = ocr_pkg::RING_DEPTH_DEF,
   parameter int MAX_BATCH    = ocr_pkg::MAX_BATCH_DEF,
   parameter int PAYLOAD_BITS = ocr_pkg::PAYLOAD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ocr_pkg::req_type                  req_data,
   input  logic                              csr_valid,
   input  logic [ocr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ocr_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              rsp_stall,
   input  ocr_pkg::cmd_type                  cmd,
   output ocr_pkg::stat_type                 stat,
   output logic                              rsp_valid,
   output ocr_pkg::rsp_type                  rsp_data
);

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam int CNT_W = PTR_W + 1;
   localparam int IW    = (CNT_W > 11) ? CNT_W : 11;
   localparam int BC_W  = $clog2(MAX_BATCH + 1);
   localparam int BI_W  = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
   localparam int GW    = 32 + BC_W;
   localparam int MW    = PAYLOAD_BITS + 34;

   logic [MW-1:0] mem [RING_DEPTH];
   logic [MW-1:0] rd_q_ff;

   ocr_pkg::req_type req_ff, req_in;
   logic [PTR_W-1:0] enq_ff, enq_in, clm_ff, clm_in, cmp_ff, cmp_in, deq_ff, deq_in;
   logic [CNT_W-1:0] occ_ff, occ_in, pend_ff, pend_in, infl_ff, infl_in, rdy_ff, rdy_in;
   logic             closed_ff, closed_in;
   logic [10:0]      len_ff, len_in;
   logic [31:0]      budget_ff, budget_in;
   logic [GW-1:0]    gath_ff, gath_in;
   logic [BC_W-1:0]  buf_cnt_ff, buf_cnt_in;
   logic [BI_W-1:0]  emit_idx_ff, emit_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ocr_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [2:0]  buf_st   [MAX_BATCH];
   logic [9:0]  buf_slot [MAX_BATCH];
   logic        buf_vld  [MAX_BATCH];
   logic [63:0] buf_data [MAX_BATCH];
   logic        buf_eos  [MAX_BATCH];

   logic [IW-1:0]    len_x, eff, sidx_x, cmp_x, off, pend_x, rdy_x;
   logic [IW-1:0]    enq_x, clm_x, deq_x;
   logic             budget_ok;
   logic [PTR_W-1:0] rd_addr, wr_addr;
   logic             wr_en;
   logic [MW-1:0]    wr_data;
   logic             push_en, push_vld, push_eos;
   logic [2:0]       push_st;
   logic [9:0]       push_slot;
   logic [63:0]      push_data;
   logic [63:0]      rd_data64;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p,
                                             input logic [IW-1:0] e);
      logic [IW-1:0] n;
      n = IW'(p) + IW'(1);
      return (n >= e) ? '0 : n[PTR_W-1:0];
   endfunction

   always_comb begin
      len_x  = IW'(len_ff);
      if (len_x == '0) begin
         eff = IW'(1);
      end else if (len_x > IW'(RING_DEPTH)) begin
         eff = IW'(RING_DEPTH);
      end else begin
         eff = len_x;
      end
      sidx_x    = IW'(req_ff.slot_index);
      cmp_x     = IW'(cmp_ff);
      enq_x     = IW'(enq_ff);
      clm_x     = IW'(clm_ff);
      deq_x     = IW'(deq_ff);
      pend_x    = IW'(pend_ff);
      rdy_x     = IW'(rdy_ff);
      off       = (sidx_x >= cmp_x) ? (sidx_x - cmp_x) : (sidx_x + eff - cmp_x);
      budget_ok = ((budget_ff == '0) && (buf_cnt_ff == '0)) || (gath_ff < GW'(budget_ff));
      rd_data64 = 64'(rd_q_ff[MW-1:34]);
   end

   always_comb begin
      stat.req_mode   = req_data.mode;
      stat.closed     = closed_ff;
      stat.full       = IW'(occ_ff) >= eff;
      stat.pend_zero  = (pend_ff == '0);
      stat.infl_zero  = (infl_ff == '0);
      stat.rdy_zero   = (rdy_ff == '0);
      stat.rd_done    = rd_q_ff[1];
      stat.rd_end     = rd_q_ff[0];
      stat.range_bad  = (sidx_x >= eff) || (off >= IW'(infl_ff));
      stat.claim_stop = (pend_ff == '0) || (buf_cnt_ff >= BC_W'(MAX_BATCH)) || !budget_ok;
      stat.buf_empty  = (buf_cnt_ff == '0);
      stat.emit_last  = ((BC_W'(emit_idx_ff) + BC_W'(1)) == buf_cnt_ff);
      stat.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      unique case (cmd.rd_sel)
         ocr_pkg::RD_CLAIM: rd_addr = clm_ff;
         ocr_pkg::RD_CMP:   rd_addr = cmp_ff;
         ocr_pkg::RD_DEQ:   rd_addr = deq_ff;
         default:           rd_addr = sidx_x[PTR_W-1:0];
      endcase
      wr_en = cmd.do_store || cmd.do_cmp;
      if (cmd.do_store) begin
         wr_addr = enq_ff;
         if (req_ff.mode == ocr_pkg::MODE_FIN) begin
            wr_data = {{PAYLOAD_BITS{1'b0}}, 32'd0, 1'b1, 1'b1};
         end else begin
            wr_data = {req_ff.payload[PAYLOAD_BITS-1:0], req_ff.item_cost,
                       (req_ff.item_cost == '0), 1'b0};
         end
      end else begin
         wr_addr = sidx_x[PTR_W-1:0];
         wr_data = {req_ff.payload[PAYLOAD_BITS-1:0], rd_q_ff[33:2], 1'b1, rd_q_ff[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      push_en   = 1'b1;
      push_st   = ocr_pkg::ST_OK;
      push_slot = '0;
      push_vld  = 1'b0;
      push_data = '0;
      push_eos  = 1'b0;
      if (cmd.push_err) begin
         push_st = cmd.err_code;
      end else if (cmd.do_store) begin
         push_slot = enq_x[9:0];
      end else if (cmd.claim_adv && !rd_q_ff[1]) begin
         push_slot = clm_x[9:0];
         push_vld  = 1'b1;
         push_data = rd_data64;
      end else if (cmd.do_cmp) begin
         push_slot = sidx_x[9:0];
      end else if (cmd.deq_pop) begin
         push_slot = deq_x[9:0];
         push_vld  = 1'b1;
         push_data = rd_data64;
      end else if (cmd.do_clear) begin
         push_slot = deq_x[9:0];
         push_eos  = 1'b1;
      end else begin
         push_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         buf_st[buf_cnt_ff[BI_W-1:0]]   <= push_st;
         buf_slot[buf_cnt_ff[BI_W-1:0]] <= push_slot;
         buf_vld[buf_cnt_ff[BI_W-1:0]]  <= push_vld;
         buf_data[buf_cnt_ff[BI_W-1:0]] <= push_data;
         buf_eos[buf_cnt_ff[BI_W-1:0]]  <= push_eos;
      end
   end

   always_comb begin
      req_in      = req_ff;
      enq_in      = enq_ff;
      clm_in      = clm_ff;
      cmp_in      = cmp_ff;
      deq_in      = deq_ff;
      occ_in      = occ_ff;
      pend_in     = pend_ff;
      infl_in     = infl_ff;
      rdy_in      = rdy_ff;
      closed_in   = closed_ff;
      len_in      = len_ff;
      budget_in   = budget_ff;
      gath_in     = gath_ff;
      buf_cnt_in  = buf_cnt_ff;
      emit_idx_in = emit_idx_ff;

      if (cmd.take_req) begin
         req_in      = req_data;
         buf_cnt_in  = '0;
         emit_idx_in = '0;
         gath_in     = '0;
      end
      if (cmd.do_store) begin
         enq_in  = bump(enq_ff, eff);
         occ_in  = occ_ff + CNT_W'(1);
         pend_in = pend_ff + CNT_W'(1);
         if (req_ff.mode == ocr_pkg::MODE_FIN) begin
            closed_in = 1'b1;
         end
      end
      if (cmd.claim_adv || cmd.sw1_step) begin
         clm_in  = bump(clm_ff, eff);
         pend_in = pend_ff - CNT_W'(1);
         infl_in = infl_ff + CNT_W'(1);
      end
      if (cmd.claim_adv && !rd_q_ff[1]) begin
         gath_in = gath_ff + GW'(rd_q_ff[33:2]);
      end
      if (cmd.sw2_step) begin
         cmp_in  = bump(cmp_ff, eff);
         infl_in = infl_ff - CNT_W'(1);
         rdy_in  = rdy_ff + CNT_W'(1);
      end
      if (cmd.deq_pop) begin
         deq_in = bump(deq_ff, eff);
         rdy_in = rdy_ff - CNT_W'(1);
         occ_in = occ_ff - CNT_W'(1);
      end
      if (cmd.do_clear) begin
         enq_in    = '0;
         clm_in    = '0;
         cmp_in    = '0;
         deq_in    = '0;
         occ_in    = '0;
         pend_in   = '0;
         infl_in   = '0;
         rdy_in    = '0;
         closed_in = 1'b0;
      end
      if (push_en) begin
         buf_cnt_in = buf_cnt_ff + BC_W'(1);
      end
      if (cmd.emit_load) begin
         emit_idx_in = emit_idx_ff + BI_W'(1);
      end
      if (csr_valid) begin
         if (csr_index == ocr_pkg::REG_RING_LENGTH) begin
            len_in = csr_wdata[10:0];
         end else if (csr_index == ocr_pkg::REG_BATCH_BUDGET) begin
            budget_in = csr_wdata;
         end
      end
   end

   always_comb begin
      rsp_data_in                 = rsp_data_ff;
      rsp_valid_in                = rsp_stall ? rsp_valid_ff : 1'b0;
      if (cmd.emit_load) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.status          = buf_st[emit_idx_ff];
         rsp_data_in.claimed_slot    = buf_slot[emit_idx_ff];
         rsp_data_in.item_valid      = buf_vld[emit_idx_ff];
         rsp_data_in.data_out        = buf_data[emit_idx_ff];
         rsp_data_in.end_of_stream   = buf_eos[emit_idx_ff];
         rsp_data_in.last_of_run     = stat.emit_last;
         rsp_data_in.unclaimed_count = pend_x[10:0];
         rsp_data_in.ready_count     = rdy_x[10:0];
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      gath_ff     <= gath_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         enq_ff       <= '0;
         clm_ff       <= '0;
         cmp_ff       <= '0;
         deq_ff       <= '0;
         occ_ff       <= '0;
         pend_ff      <= '0;
         infl_ff      <= '0;
         rdy_ff       <= '0;
         closed_ff    <= 1'b0;
         len_ff       <= ocr_pkg::RING_LENGTH_RESET;
         budget_ff    <= '0;
         buf_cnt_ff   <= '0;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enq_ff       <= enq_in;
         clm_ff       <= clm_in;
         cmp_ff       <= cmp_in;
         deq_ff       <= deq_in;
         occ_ff       <= occ_in;
         pend_ff      <= pend_in;
         infl_ff      <= infl_in;
         rdy_ff       <= rdy_in;
         closed_ff    <= closed_in;
         len_ff       <= len_in;
         budget_ff    <= budget_in;
         buf_cnt_ff   <= buf_cnt_in;
         emit_idx_ff  <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import ocr_pkg::*;

   class ring_predictor;
      logic [10:0] ring_length;
      logic [31:0] batch_budget;
      logic [63:0] slot_data [1024];
      logic [31:0] slot_cost [1024];
      bit          slot_done [1024];
      bit          slot_end [1024];
      int          enq_ptr, claim_ptr, cmp_ptr, deq_ptr;
      int          occupancy, pending, in_flight, ready;
      bit          closed;
      rsp_type     expected [$];
      int          mismatches;

      function void clear();
         for (int i = 0; i < 1024; i++) begin
            slot_data[i] = '0;
            slot_cost[i] = '0;
            slot_done[i] = 0;
            slot_end[i] = 0;
         end
         enq_ptr = 0; claim_ptr = 0; cmp_ptr = 0; deq_ptr = 0;
         occupancy = 0; pending = 0; in_flight = 0; ready = 0;
         closed = 0;
      endfunction

      function void reset_all();
         ring_length = RING_LENGTH_RESET;
         batch_budget = '0;
         mismatches = 0;
         clear();
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
         if (idx == REG_RING_LENGTH) ring_length = value[10:0];
         else if (idx == REG_BATCH_BUDGET) batch_budget = value;
      endfunction

      function int eff_len();
         if (ring_length == 0) return 1;
         if (ring_length > 1024) return 1024;
         return ring_length;
      endfunction

      function int bump(int p);
         return (p + 1 >= eff_len()) ? 0 : p + 1;
      endfunction

      function void sweep();
         while (pending > 0 && slot_done[claim_ptr]) begin
            claim_ptr = bump(claim_ptr);
            pending--;
            in_flight++;
         end
         while (in_flight > 0 && slot_done[cmp_ptr]) begin
            cmp_ptr = bump(cmp_ptr);
            in_flight--;
            ready++;
         end
      endfunction

      function rsp_type make(logic [2:0] st, int slot, bit valid, logic [63:0] data, bit eos);
         rsp_type r;
         r = '0;
         r.status = st;
         r.claimed_slot = slot[9:0];
         r.item_valid = valid;
         r.data_out = data;
         r.end_of_stream = eos;
         return r;
      endfunction

      function rsp_type store(logic [63:0] data, logic [31:0] cost, bit is_end);
         int s;
         if (closed) return make(ST_CLOSED, 0, 0, '0, 0);
         if (occupancy >= eff_len()) return make(ST_FULL, 0, 0, '0, 0);
         s = enq_ptr;
         slot_data[s] = data;
         slot_cost[s] = cost;
         slot_done[s] = (cost == 0);
         slot_end[s] = is_end;
         enq_ptr = bump(enq_ptr);
         occupancy++;
         pending++;
         if (is_end) closed = 1;
         sweep();
         return make(ST_OK, s, 0, '0, 0);
      endfunction

      function void note_request(req_type q);
         rsp_type     outs [$];
         logic [63:0] gathered;
         logic [31:0] off;
         int          s;
         bit          budget_ok;
         case (q.mode)
            MODE_ENQ: outs.push_back(store(q.payload, q.item_cost, 0));
            MODE_FIN: outs.push_back(store('0, '0, 1));
            MODE_CLAIM: begin
               gathered = '0;
               forever begin
                  budget_ok = (batch_budget == 0 && outs.size() == 0) ||
                              gathered < batch_budget;
                  if (pending == 0 || outs.size() >= 16 || !budget_ok) break;
                  s = claim_ptr;
                  if (!slot_done[s]) begin
                     gathered += slot_cost[s];
                     outs.push_back(make(ST_OK, s, 1, slot_data[s], 0));
                  end
                  claim_ptr = bump(claim_ptr);
                  pending--;
                  in_flight++;
               end
               sweep();
               if (outs.size() == 0) outs.push_back(make(ST_NONE, 0, 0, '0, 0));
            end
            MODE_CMP: begin
               off = (q.slot_index >= cmp_ptr) ? q.slot_index - cmp_ptr
                                               : q.slot_index + eff_len() - cmp_ptr;
               if (q.slot_index >= eff_len() || off >= in_flight || slot_done[q.slot_index])
               begin
                  outs.push_back(make(ST_BAD, 0, 0, '0, 0));
               end else begin
                  slot_data[q.slot_index] = q.payload;
                  slot_done[q.slot_index] = 1;
                  sweep();
                  outs.push_back(make(ST_OK, q.slot_index, 0, '0, 0));
               end
            end
            MODE_DEQ: begin
               if (ready == 0) begin
                  outs.push_back(make(ST_NONE, 0, 0, '0, 0));
               end else begin
                  s = deq_ptr;
                  if (slot_end[s]) begin
                     clear();
                     outs.push_back(make(ST_OK, s, 0, '0, 1));
                  end else begin
                     deq_ptr = bump(deq_ptr);
                     ready--;
                     occupancy--;
                     outs.push_back(make(ST_OK, s, 1, slot_data[s], 0));
                  end
               end
            end
            default: ;
         endcase
         foreach (outs[k]) begin
            outs[k].last_of_run = (k == outs.size() - 1);
            outs[k].unclaimed_count = pending[10:0];
            outs[k].ready_count = ready[10:0];
            expected.push_back(outs[k]);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
         end
         e = expected.pop_front();
         if (got.status !== e.status || got.claimed_slot !== e.claimed_slot ||
             got.item_valid !== e.item_valid || got.data_out !== e.data_out ||
             got.end_of_stream !== e.end_of_stream || got.last_of_run !== e.last_of_run ||
             got.unclaimed_count !== e.unclaimed_count || got.ready_count !== e.ready_count)
         begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %h, got %h", e, got);
         end
      endfunction

      // Picks a claimed slot that has not yet been completed, or -1.
      function int open_slot();
         int cands [$];
         int p;
         p = cmp_ptr;
         for (int i = 0; i < in_flight; i++) begin
            if (!slot_done[p]) cands.push_back(p);
            p = bump(p);
         end
         if (cands.size() == 0) return -1;
         return cands[$urandom_range(0, cands.size() - 1)];
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ring_predictor ring = new();
   bit  no_idle;
   bit  hold_request;
   int  stall_pct;
   int  quiet_cycles;

   ordered_completion_ring_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_request(req_type q);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (req_stall);
      ring.note_request(q);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      ring.write_reg(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function req_type build(logic [2:0] mode, logic [31:0] cost, logic [63:0] data,
                           logic [9:0] slot);
      req_type q;
      q.mode = mode;
      q.item_cost = cost;
      q.payload = data;
      q.slot_index = slot;
      return q;
   endfunction

   function logic [63:0] rand_payload();
      return {$urandom, $urandom};
   endfunction

   function logic [31:0] rand_cost();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) return '0;
      if (r < 85) return $urandom_range(1, 20);
      return $urandom;
   endfunction

   task automatic complete_one(bit well_formed);
      int s;
      s = ring.open_slot();
      if (!well_formed || s < 0) s = $urandom_range(0, 1023);
      send_request(build(MODE_CMP, $urandom, rand_payload(), s[9:0]));
   endtask

   // Brings the ring back to its reset state through the end marker.
   task automatic drain_ring();
      bit finished;
      finished = 0;
      while (!finished) begin
         if (ring.ready > 0) begin
            finished = ring.slot_end[ring.deq_ptr];
            send_request(build(MODE_DEQ, $urandom, rand_payload(), 10'($urandom)));
         end else if (!ring.closed && ring.occupancy < ring.eff_len()) begin
            send_request(build(MODE_FIN, $urandom, rand_payload(), 10'($urandom)));
         end else if (ring.open_slot() >= 0) begin
            complete_one(1);
         end else begin
            send_request(build(MODE_CLAIM, $urandom, rand_payload(), 10'($urandom)));
         end
      end
   endtask

   task automatic random_phase(int count);
      int done_items;
      int r;
      done_items = 0;
      while (done_items < count) begin
         r = $urandom_range(0, 99);
         done_items++;
         if (r < 36) begin
            send_request(build(MODE_ENQ, rand_cost(), rand_payload(), 10'($urandom)));
         end else if (r < 56) begin
            send_request(build(MODE_CLAIM, $urandom, rand_payload(), 10'($urandom)));
         end else if (r < 78) begin
            complete_one($urandom_range(0, 9) < 8);
         end else if (r < 95) begin
            send_request(build(MODE_DEQ, $urandom, rand_payload(), 10'($urandom)));
         end else if (r < 97) begin
            send_request(build(MODE_FIN, $urandom, rand_payload(), 10'($urandom)));
         end else begin
            done_items--;
            send_request(build(3'($urandom_range(5, 7)), $urandom, rand_payload(),
                               10'($urandom)));
         end
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (ring.expected.size() != 0) @(posedge clock);
      repeat (5000) @(posedge clock);
   endtask

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         int hold_left;
         int burst;
         @(posedge clock);
         if (rsp_valid && !rsp_stall) ring.check_result(rsp_data);
         if (hold_request) begin
            hold_request = 0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (burst > 0) begin
            burst--;
            rsp_stall <= 1'b1;
         end else if (!no_idle && $urandom_range(0, 99) < stall_pct) begin
            if ($urandom_range(0, 19) == 0) burst = $urandom_range(10, 50);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= 30000) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      logic [10:0] lengths [7];
      logic [31:0] budgets [7];
      lengths = '{11'd1024, 11'd4, 11'd1, 11'd0, 11'd16, 11'd2047, 11'd1024};
      budgets = '{32'd0, 32'd0, 32'd1, 32'hFFFFFFFF, 32'd37, 32'd5, 32'd1000};
      ring.reset_all();
      no_idle = 0;
      hold_request = 0;
      stall_pct = 25;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(build(MODE_DEQ, '0, '0, '0));
      send_request(build(MODE_CLAIM, '0, '0, '0));
      send_request(build(MODE_CMP, '0, '0, 10'd1023));
      send_request(build(MODE_ENQ, '0, 64'h0123456789ABCDEF, '0));
      send_request(build(MODE_ENQ, 32'hFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 10'h3FF));
      send_request(build(MODE_ENQ, 32'd1, '0, '0));
      send_request(build(MODE_ENQ, 32'd2, 64'h8000000000000001, '0));
      send_request(build(MODE_CLAIM, '0, '0, '0));
      complete_one(1);
      send_request(build(MODE_CMP, '0, '0, 10'd1));
      send_request(build(MODE_CMP, '0, '0, 10'd2));
      send_request(build(MODE_DEQ, '0, '0, '0));
      send_request(build(MODE_DEQ, '0, '0, '0));
      send_request(build(3'd5, '0, '0, '0));
      send_request(build(3'd7, 32'hFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 10'h3FF));
      send_request(build(MODE_FIN, '0, '0, '0));
      send_request(build(MODE_ENQ, 32'd3, 64'd9, '0));
      send_request(build(MODE_FIN, '0, '0, '0));
      send_request(build(MODE_CLAIM, '0, '0, '0));
      drain_ring();
      settle();

      for (int ph = 0; ph < 7; ph++) begin
         write_csr(REG_RING_LENGTH, {21'd0, lengths[ph]});
         write_csr(REG_BATCH_BUDGET, budgets[ph]);
         no_idle = (ph == 2);
         stall_pct = (ph == 4) ? 60 : 25;
         if (ph == 1) hold_request = 1;
         random_phase(45);
         drain_ring();
         settle();
      end

      if (ring.mismatches == 0 && ring.expected.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/ocr_pkg.sv
sv/ocr_ctrl.sv
sv/ocr_dpath.sv
sv/ordered_completion_ring_core.sv
bench/testbench.sv
